>>> hw/rtl/polynomial_feature_predict_macros.svh
// Assertion macros for the polynomial predictor checker
`ifndef POLYNOMIAL_FEATURE_PREDICT_MACROS_SVH
`define POLYNOMIAL_FEATURE_PREDICT_MACROS_SVH

// Checked outside reset only
`define PFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included
`define PFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hw/rtl/pfp_pkg.sv
// Shared constants, payload types and control struct for the polynomial predictor
package pfp_pkg;

    localparam int MAX_FEATURES = 16;
    localparam int MAX_DEGREE   = 4;
    localparam int STORE_DEPTH  = 1 + MAX_FEATURES * MAX_DEGREE;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int POS_W        = $clog2(MAX_FEATURES + 1);
    localparam int CNT_W        = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DEG_W        = 3;
    localparam int FCNT_W       = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int DATA_W       = 32;
    localparam int ACC_W        = 48;
    localparam int FRAC_W       = 16;
    localparam int PROD_W       = 2 * DATA_W;

    typedef enum logic {
        OP_WEIGHT  = 1'b0,
        OP_FEATURE = 1'b1
    } opcode_t;

    typedef enum logic {
        CFG_DEGREE        = 1'b0,
        CFG_FEATURE_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic [6:0]                weight_index;
        logic signed [DATA_W-1:0]  value;
        logic                      last;
    } pfp_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  prediction;
        logic                      overflow;
    } pfp_out_t;

    // Sequencer to term unit
    typedef struct packed {
        logic start;      // new feature: latch x, power starts at x
        logic load_bias;  // first feature of an instance: accumulator from bias
        logic bias_wr;    // weight transaction to index 0
        logic mul_en;     // weight word valid: form weight product
        logic pow_en;     // another term follows: advance the power
        logic add_en;     // fold registered product into accumulator
        logic emit;       // prediction taken: clear accumulator and flag
    } term_ctrl_t;

endpackage

>>> hw/rtl/pfp_weight_ram.sv
// Weight store: one write port, one read port with registered read data
module pfp_weight_ram #(
    parameter int DEPTH = 65,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/pfp_term_unit.sv
// Power chain, weight multiply and saturating 48-bit accumulator
module pfp_term_unit import pfp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  term_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic signed [DATA_W-1:0] rd_data,
    output logic signed [DATA_W-1:0] pred,
    output logic                     ovf
);

    localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]  MAXAC = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  MINAC = {1'b1, {(ACC_W-1){1'b0}}};
    localparam int HI_W = PROD_W - FRAC_W - DATA_W + 1;
    localparam int AH_W = ACC_W - DATA_W + 1;

    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] p_reg, p_next;
    logic signed [DATA_W-1:0] bias_reg, bias_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     flag_reg, flag_next;

    logic signed [PROD_W-1:0] pprod;
    logic [HI_W-1:0]          pow_hi;
    logic                     pow_sat;
    logic signed [DATA_W-1:0] pow_val;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W:0]    sum;
    logic                     add_sat;
    logic [AH_W-1:0]          acc_hi;
    logic                     out_sat;

    always_comb begin
        pprod     = PROD_W'(p_reg) * PROD_W'(x_reg);
        prod_next = PROD_W'(rd_data) * PROD_W'(p_reg);

        // power floor-shifted, then narrowed to 32 bits
        pow_hi  = pprod[PROD_W-1 -: HI_W];
        pow_sat = !((pow_hi == '0) || (pow_hi == '1));
        if (pow_sat) begin
            pow_val = pprod[PROD_W-1] ? MIN32 : MAX32;
        end else begin
            pow_val = pprod[FRAC_W +: DATA_W];
        end

        term    = prod_reg[PROD_W-1 -: ACC_W];
        sum     = {acc_reg[ACC_W-1], acc_reg} + {term[ACC_W-1], term};
        add_sat = sum[ACC_W] != sum[ACC_W-1];

        acc_hi  = acc_reg[ACC_W-1 -: AH_W];
        out_sat = !((acc_hi == '0) || (acc_hi == '1));
        if (out_sat) begin
            pred = acc_reg[ACC_W-1] ? MIN32 : MAX32;
        end else begin
            pred = acc_reg[DATA_W-1:0];
        end
        ovf = flag_reg | out_sat;

        x_next    = x_reg;
        p_next    = p_reg;
        bias_next = bias_reg;
        acc_next  = acc_reg;
        flag_next = flag_reg;

        if (ctrl.bias_wr) begin
            bias_next = in_value;
        end
        if (ctrl.start) begin
            x_next = in_value;
            p_next = in_value;
            if (ctrl.load_bias) begin
                acc_next = ACC_W'(bias_reg);
            end
        end
        if (ctrl.pow_en) begin
            p_next    = pow_val;
            flag_next = flag_next | pow_sat;
        end
        if (ctrl.add_en) begin
            if (add_sat) begin
                acc_next = sum[ACC_W] ? MINAC : MAXAC;
            end else begin
                acc_next = sum[ACC_W-1:0];
            end
            flag_next = flag_next | add_sat;
        end
        if (ctrl.emit) begin
            acc_next  = '0;
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            flag_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        p_reg    <= p_next;
        bias_reg <= bias_next;
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

>>> hw/rtl/polynomial_feature_predict.sv
// Top level: polynomial regression predictor, signed Q16.16, weights in a 65-entry RAM.
// Weight transaction, or a feature beyond the count: no RAM read. Other features run the
// RAM read, weight multiply and accumulate stages in series, once per power up to the
// clamped degree; the feature marked last then loads the result register in ST_FIN.
// Result register lets the next transaction in while a prediction waits.
// Reset: synchronous active-low; clears control, accumulator, flag; weights undefined.
module polynomial_feature_predict import pfp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pfp_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pfp_out_t              m_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [DEG_W-1:0]    degree_reg, degree_next;
    logic [FCNT_W-1:0]   fcount_reg, fcount_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                last_reg, last_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                add_vld_reg, add_vld_next;
    logic                m_valid_reg, m_valid_next;
    pfp_out_t            m_data_reg, m_data_next;

    logic [DEG_W-1:0]    nd;
    logic [POS_W-1:0]    nf;
    logic [ADDR_W-1:0]   pow_base;
    logic                s_accept;
    term_ctrl_t          ctrl;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic signed [DATA_W-1:0] pred;
    logic                ovf;

    always_comb begin
        if (degree_reg == '0) begin
            nd = DEG_W'(1);
        end else if (degree_reg > DEG_W'(MAX_DEGREE)) begin
            nd = DEG_W'(MAX_DEGREE);
        end else begin
            nd = degree_reg;
        end
        if (fcount_reg == '0) begin
            nf = POS_W'(1);
        end else if (fcount_reg > FCNT_W'(MAX_FEATURES)) begin
            nf = POS_W'(MAX_FEATURES);
        end else begin
            nf = POS_W'(fcount_reg);
        end
        // higher powers of feature i start at 1 + F + i*(D-1)
        pow_base = ADDR_W'(1) + ADDR_W'(nf)
                 + ADDR_W'(pos_reg) * ADDR_W'(nd - DEG_W'(1));
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        degree_next  = degree_reg;
        fcount_next  = fcount_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        rem_next     = rem_reg;
        addr_next    = addr_reg;
        rd_vld_next  = 1'b0;
        add_vld_next = 1'b0;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ctrl         = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = addr_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_DEGREE:        degree_next = cfg_wdata[DEG_W-1:0];
                CFG_FEATURE_COUNT: fcount_next = cfg_wdata[FCNT_W-1:0];
                default:           ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_data.opcode == OP_WEIGHT) begin
                        ram_we       = (s_data.weight_index < 7'(STORE_DEPTH));
                        ctrl.bias_wr = (s_data.weight_index == '0);
                    end else begin
                        last_next      = s_data.last;
                        ctrl.start     = 1'b1;
                        ctrl.load_bias = (pos_reg == '0);
                        if (pos_reg < nf) begin
                            ram_re      = 1'b1;
                            ram_raddr   = ADDR_W'(1) + ADDR_W'(pos_reg);
                            rd_vld_next = 1'b1;
                            rem_next    = CNT_W'(nd - DEG_W'(1));
                            addr_next   = pow_base;
                            pos_next    = pos_reg + POS_W'(1);
                            state_next  = ST_RUN;
                        end else if (s_data.last) begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_RUN: begin
                ctrl.mul_en  = rd_vld_reg;
                ctrl.add_en  = add_vld_reg;
                add_vld_next = rd_vld_reg;
                if (rem_reg != '0) begin
                    ram_re      = 1'b1;
                    addr_next   = addr_reg + ADDR_W'(1);
                    rem_next    = rem_reg - CNT_W'(1);
                    rd_vld_next = 1'b1;
                    ctrl.pow_en = rd_vld_reg;
                end
                // the add in this cycle, if any, is the final one
                if ((rem_reg == '0) && !rd_vld_reg) begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.prediction = pred;
                    m_data_next.overflow   = ovf;
                    ctrl.emit              = 1'b1;
                    pos_next               = '0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            degree_reg  <= DEG_W'(1);
            fcount_reg  <= FCNT_W'(1);
            pos_reg     <= '0;
            last_reg    <= 1'b0;
            rem_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            add_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            degree_reg  <= degree_next;
            fcount_reg  <= fcount_next;
            pos_reg     <= pos_next;
            last_reg    <= last_next;
            rem_reg     <= rem_next;
            rd_vld_reg  <= rd_vld_next;
            add_vld_reg <= add_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    pfp_weight_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (DATA_W)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_data.weight_index[ADDR_W-1:0]),
        .wdata (s_data.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfp_term_unit u_term_unit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .in_value (s_data.value),
        .rd_data  (ram_rdata),
        .pred     (pred),
        .ovf      (ovf)
    );

endmodule

>>> hw/rtl/pfp_checker.sv
// Port-level checker for the polynomial predictor, bound to the top level
`include "polynomial_feature_predict_macros.svh"

module pfp_checker import pfp_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input pfp_in_t               s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input pfp_out_t              m_data
);

    `PFP_ASSERT_ALWAYS(a_reset_no_result, !aresetn |=> !m_valid, "result valid after reset")
    `PFP_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped or changed while stalled")
    `PFP_ASSERT(a_weight_no_result, s_valid && s_ready && (s_data.opcode == OP_WEIGHT) && !m_valid |=> !m_valid, "weight transaction produced a result")
    // a last feature always leaves the sequencer busy in the cycle after it is accepted
    `PFP_ASSERT(a_last_busy, s_valid && s_ready && (s_data.opcode == OP_FEATURE) && s_data.last |=> !s_ready, "last feature did not occupy the sequencer")

endmodule

bind polynomial_feature_predict pfp_checker u_pfp_checker (.*);
